[src/aik_pkg.sv]
// shared constants, widths and the cordic angle table of the arm inverse kinematics block
`default_nettype none

package aik_pkg;

    localparam int COORD_W      = 24;
    localparam int LEN_W        = 23;
    localparam int ANG_W        = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int NORM_MSB     = 29;
    localparam int CX_W         = 33;
    localparam int Z_W          = 22;
    localparam int SQ1_IN_W     = 48;
    localparam int SQ2_IN_W     = 34;
    localparam int DIV_W        = 64;
    localparam int Q_W          = 17;
    localparam int DEN_W        = 47;
    localparam int AT_LAT       = 3 + CORDIC_STEPS + 1;

    localparam logic [1:0] CFG_SHOULDER_OFFSET   = 2'd0;
    localparam logic [1:0] CFG_UPPER_LINK_LENGTH = 2'd1;
    localparam logic [1:0] CFG_FORE_LINK_LENGTH  = 2'd2;
    localparam logic [1:0] CFG_BASE_HEIGHT       = 2'd3;

    // atan(2^-i) in units of pi/2^20
    function automatic logic [Z_W-1:0] f_atan_step(input int idx);
        logic [Z_W-1:0] v;
        unique case (idx)
            0:  v = Z_W'(262144);
            1:  v = Z_W'(154753);
            2:  v = Z_W'(81767);
            3:  v = Z_W'(41506);
            4:  v = Z_W'(20834);
            5:  v = Z_W'(10427);
            6:  v = Z_W'(5215);
            7:  v = Z_W'(2608);
            8:  v = Z_W'(1304);
            9:  v = Z_W'(652);
            10: v = Z_W'(326);
            11: v = Z_W'(163);
            12: v = Z_W'(81);
            13: v = Z_W'(41);
            14: v = Z_W'(20);
            15: v = Z_W'(10);
            16: v = Z_W'(5);
            17: v = Z_W'(3);
            18: v = Z_W'(1);
            19: v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[src/aik_delay.sv]
// data delay line of fixed depth that advances with the pipeline enable
`default_nettype none

module aik_delay
    import aik_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [WIDTH-1:0] i_d,
    output logic      [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

`default_nettype wire

[src/aik_isqrt.sv]
// pipelined floor square root, one result bit per stage
`default_nettype none

module aik_isqrt
    import aik_pkg::*;
#(
    parameter int W = SQ1_IN_W
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire logic [W-1:0]   i_val,
    output logic      [W/2-1:0] o_root
);

    localparam int K = W / 2;

    logic [W-1:0] r_rem [K];
    logic [W-1:0] r_res [K];

    for (genvar k = 0; k < K; k++) begin : g_stage
        localparam logic [W:0] BIT = (W+1)'(1) << (W - 2 - 2 * k);
        logic [W-1:0] prev_rem;
        logic [W-1:0] prev_res;
        logic [W:0]   trial;
        logic         take;
        logic [W-1:0] n_rem;
        logic [W-1:0] n_res;

        if (k == 0) begin : g_first
            assign prev_rem = i_val;
            assign prev_res = '0;
        end else begin : g_next
            assign prev_rem = r_rem[k-1];
            assign prev_res = r_res[k-1];
        end

        always_comb begin
            trial = {1'b0, prev_res} + BIT;
            take  = ({1'b0, prev_rem} >= trial);
            n_rem = take ? (prev_rem - trial[W-1:0]) : prev_rem;
            n_res = take ? ((prev_res >> 1) + BIT[W-1:0]) : (prev_res >> 1);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[k] <= n_res;
            end
        end

        if (k < K - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                end
            end
        end
    end

    assign o_root = r_res[K-1][K-1:0];

endmodule

`default_nettype wire

[src/aik_div.sv]
// pipelined restoring divider for the elbow cosine quotient, one quotient bit per stage
`default_nettype none

module aik_div
    import aik_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [DIV_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [Q_W-1:0]   o_quo
);

    logic [DIV_W-1:0] r_rem [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic [DIV_W-1:0] prev_rem;
        logic [Q_W-1:0]   prev_quo;
        logic [DIV_W-1:0] shifted;
        logic             take;
        logic [DIV_W-1:0] n_rem;
        logic [Q_W-1:0]   n_quo;

        if (k == 0) begin : g_first
            assign prev_rem = i_num;
            assign prev_quo = '0;
        end else begin : g_next
            assign prev_rem = r_rem[k-1];
            assign prev_quo = r_quo[k-1];
        end

        always_comb begin
            shifted = {{(DIV_W-DEN_W){1'b0}}, i_den} << B;
            take    = (prev_rem >= shifted);
            n_rem   = take ? (prev_rem - shifted) : prev_rem;
            n_quo   = prev_quo | (Q_W'(take) << B);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= n_quo;
            end
        end

        if (k < Q_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                end
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];

endmodule

`default_nettype wire

[src/aik_atan2.sv]
// pipelined cordic atan2: magnitude, normalize, twenty vectoring stages, quadrant map
`default_nettype none

module aik_atan2
    import aik_pkg::*;
#(
    parameter int W = COORD_W
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [W-1:0]     i_y,
    input  wire logic signed [W-1:0]     i_x,
    output logic             [ANG_W-1:0] o_ang
);

    localparam int P_W = $clog2(W);
    localparam logic signed [Z_W-1:0] A_MAX = Z_W'(16384);

    typedef struct packed {
        logic xneg;
        logic yneg;
        logic zero;
    } t_quad;

    // magnitudes
    logic [W-1:0] r_ax;
    logic [W-1:0] r_ay;
    logic         r_xneg;
    logic         r_yneg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax   <= i_x[W-1] ? (~i_x + W'(1)) : i_x;
            r_ay   <= i_y[W-1] ? (~i_y + W'(1)) : i_y;
            r_xneg <= i_x[W-1];
            r_yneg <= i_y[W-1];
        end
    end

    // leading one search
    logic [W-1:0]   n_m;
    logic [P_W-1:0] n_p;
    logic [W-1:0]   r_ax2;
    logic [W-1:0]   r_ay2;
    logic [P_W-1:0] r_p;
    t_quad          r_quad;

    always_comb begin
        n_m = (r_ax > r_ay) ? r_ax : r_ay;
        n_p = '0;
        for (int i = 0; i < W; i++) begin
            if (n_m[i]) begin
                n_p = P_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax2  <= r_ax;
            r_ay2  <= r_ay;
            r_p    <= n_p;
            r_quad <= '{xneg: r_xneg, yneg: r_yneg, zero: (n_m == '0)};
        end
    end

    // normalize so the larger magnitude lands in [2^29, 2^30)
    logic [W+NORM_MSB-1:0] n_wx;
    logic [W+NORM_MSB-1:0] n_wy;

    assign n_wx = {r_ax2, {NORM_MSB{1'b0}}} >> r_p;
    assign n_wy = {r_ay2, {NORM_MSB{1'b0}}} >> r_p;

    logic signed [CX_W-1:0] r_cx [CORDIC_STEPS];
    logic signed [CX_W-1:0] r_cy [CORDIC_STEPS];
    logic signed [Z_W-1:0]  r_z  [CORDIC_STEPS+1];
    t_quad                  r_q  [CORDIC_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= {{(CX_W-NORM_MSB-1){1'b0}}, n_wx[NORM_MSB:0]};
            r_cy[0] <= {{(CX_W-NORM_MSB-1){1'b0}}, n_wy[NORM_MSB:0]};
            r_z[0]  <= '0;
            r_q[0]  <= r_quad;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic signed [Z_W-1:0] TAB = f_atan_step(i);
        logic                   cy_neg;
        logic signed [CX_W-1:0] n_cx;
        logic signed [CX_W-1:0] n_cy;
        logic signed [Z_W-1:0]  n_z;

        always_comb begin
            cy_neg = r_cy[i][CX_W-1];
            n_cx   = cy_neg ? (r_cx[i] + (r_cy[i] >>> i)) : (r_cx[i] + (r_cy[i] >>> i));
            n_cx   = cy_neg ? (r_cx[i] - (r_cy[i] >>> i)) : n_cx;
            n_cy   = cy_neg ? (r_cy[i] + (r_cx[i] >>> i)) : (r_cy[i] - (r_cx[i] >>> i));
            n_z    = cy_neg ? (r_z[i] - TAB) : (r_z[i] + TAB);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z[i+1] <= n_z;
                r_q[i+1] <= r_q[i];
            end
        end

        if (i < CORDIC_STEPS - 1) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_cx[i+1] <= n_cx;
                    r_cy[i+1] <= n_cy;
                end
            end
        end
    end

    // round, clamp to the first quadrant and map by argument signs
    logic signed [Z_W-1:0] n_zr;
    logic signed [Z_W-1:0] n_a;
    logic [14:0]           n_cl;
    logic [ANG_W-1:0]      n_r0;
    logic [ANG_W-1:0]      n_r1;
    logic [ANG_W-1:0]      n_r2;
    logic [ANG_W-1:0]      r_ang;
    t_quad                 q_last;

    always_comb begin
        q_last = r_q[CORDIC_STEPS];
        n_zr   = r_z[CORDIC_STEPS] + Z_W'(16);
        n_a    = n_zr >>> 5;
        if (n_a[Z_W-1]) begin
            n_cl = '0;
        end else if (n_a > A_MAX) begin
            n_cl = 15'(16384);
        end else begin
            n_cl = n_a[14:0];
        end
        n_r0 = {1'b0, n_cl};
        n_r1 = q_last.xneg ? (ANG_W'(32768) - n_r0) : n_r0;
        n_r2 = q_last.yneg ? (ANG_W'(0) - n_r1) : n_r1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= q_last.zero ? '0 : n_r2;
        end
    end

    assign o_ang = r_ang;

endmodule

`default_nettype wire

[src/arm_inverse_kinematics_3dof.sv]
// top level of the three joint arm inverse kinematics pipeline
// Usage:
//   input channel: i_in_valid / o_in_stall carry one target point (x, y, z) per beat,
//   taken at a clock edge with i_in_valid high and o_in_stall low
//   output channel: o_out_valid / i_out_stall carry base, shoulder and elbow angles
//   plus the unreachable flag, taken with o_out_valid high and i_out_stall low
//   config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data,
//   ready is always high; write only while the pipeline is empty
// Path: a result passes the reach square root (24 stages), cosine divider (17 stages),
//   sine square root (17 stages) and the cordic atan2 units (24 stages) on its way
//   to the output register
// Throughput: one beat per cycle while the pipeline is not stalled, every stage registered
// Stall: when the output register is full and i_out_stall is high the whole pipeline
//   freezes and o_in_stall rises; nothing is dropped or repeated
// Reset: synchronous active low, clears valid bits and loads register defaults
`default_nettype none

module arm_inverse_kinematics_3dof
    import aik_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic signed [COORD_W-1:0] i_target_x,
    input  wire logic signed [COORD_W-1:0] i_target_y,
    input  wire logic signed [COORD_W-1:0] i_target_z,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic signed [ANG_W-1:0]        o_base_angle,
    output logic signed [ANG_W-1:0]        o_shoulder_angle,
    output logic signed [ANG_W-1:0]        o_elbow_angle,
    output logic                           o_unreachable,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [1:0]                i_cfg_index,
    input  wire logic [COORD_W-1:0]        i_cfg_data
);

    localparam int L_SQ1 = SQ1_IN_W / 2;
    localparam int L_SQ2 = SQ2_IN_W / 2;
    localparam int L_DIV = Q_W;
    localparam int T_A1  = 1;
    localparam int T_SUM = T_A1 + 1;
    localparam int T_SQ1 = T_SUM + L_SQ1;
    localparam int T_C1  = T_SQ1 + 1;
    localparam int T_C5  = T_C1 + 4;
    localparam int T_DIV = T_C5 + L_DIV;
    localparam int T_D1  = T_DIV + 1;
    localparam int T_D2  = T_D1 + 1;
    localparam int T_SQ2 = T_D2 + L_SQ2;
    localparam int T_E2  = T_SQ2 + 2;
    localparam int T_AT  = T_E2 + AT_LAT;
    localparam int T_OUT = T_AT + 1;

    // configuration registers
    logic [LEN_W-1:0]          r_shoulder_offset;
    logic [LEN_W-1:0]          r_upper_link_length;
    logic [LEN_W-1:0]          r_fore_link_length;
    logic signed [COORD_W-1:0] r_base_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shoulder_offset   <= '0;
            r_upper_link_length <= LEN_W'(4096);
            r_fore_link_length  <= LEN_W'(4096);
            r_base_height       <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SHOULDER_OFFSET:   r_shoulder_offset   <= i_cfg_data[LEN_W-1:0];
                CFG_UPPER_LINK_LENGTH: r_upper_link_length <= i_cfg_data[LEN_W-1:0];
                CFG_FORE_LINK_LENGTH:  r_fore_link_length  <= i_cfg_data[LEN_W-1:0];
                CFG_BASE_HEIGHT:       r_base_height       <= i_cfg_data;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // link length products, zero length taken as one
    logic [LEN_W-1:0]     n_l1;
    logic [LEN_W-1:0]     n_l2;
    logic [LEN_W-1:0]     r_l1;
    logic [LEN_W-1:0]     r_l2;
    logic [2*LEN_W-1:0]   r_l1sq;
    logic [2*LEN_W-1:0]   r_l2sq;
    logic [2*LEN_W-1:0]   r_l1l2;
    logic [2*LEN_W:0]     r_l12sq;
    logic [DEN_W-1:0]     w_den;

    assign n_l1  = (r_upper_link_length == '0) ? LEN_W'(1) : r_upper_link_length;
    assign n_l2  = (r_fore_link_length == '0) ? LEN_W'(1) : r_fore_link_length;
    assign w_den = {r_l1l2, 1'b0};

    always_ff @(posedge i_clk) begin
        r_l1    <= n_l1;
        r_l2    <= n_l2;
        r_l1sq  <= n_l1 * n_l1;
        r_l2sq  <= n_l2 * n_l2;
        r_l1l2  <= n_l1 * n_l2;
        r_l12sq <= {1'b0, r_l1sq} + {1'b0, r_l2sq};
    end

    // pipeline control
    logic [T_OUT:0] r_vld;
    logic           en;

    assign en          = !(r_vld[T_OUT] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[T_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[T_OUT-1:0], i_in_valid};
        end
    end

    // input register and squares
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_z;
    logic signed [47:0]        n_xx;
    logic signed [47:0]        n_yy;
    logic [46:0]               r_xx;
    logic [46:0]               r_yy;
    logic signed [COORD_W:0]   r_h1;
    logic [SQ1_IN_W-1:0]       r_sum;

    assign n_xx = r_x * r_x;
    assign n_yy = r_y * r_y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x   <= i_target_x;
            r_y   <= i_target_y;
            r_z   <= i_target_z;
            r_xx  <= n_xx[46:0];
            r_yy  <= n_yy[46:0];
            r_h1  <= {r_z[COORD_W-1], r_z} - {r_base_height[COORD_W-1], r_base_height};
            r_sum <= {1'b0, r_xx} + {1'b0, r_yy};
        end
    end

    logic [L_SQ1-1:0] w_root;

    aik_isqrt #(.W(SQ1_IN_W)) u_sqrt_reach (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_sum),
        .o_root (w_root)
    );

    logic signed [COORD_W:0] w_height;

    aik_delay #(.WIDTH(COORD_W + 1), .DEPTH(T_C1 - T_A1)) u_dly_height (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_h1),
        .o_q   (w_height)
    );

    // reach, squared distance and cosine numerator
    logic signed [COORD_W:0] r_reach;
    logic signed [49:0]      n_r2;
    logic signed [49:0]      n_h2;
    logic [48:0]             r_r2;
    logic [48:0]             r_h2;
    logic [49:0]             r_a;
    logic signed [50:0]      n_num;
    logic signed [50:0]      r_num;

    assign n_r2  = r_reach * r_reach;
    assign n_h2  = w_height * w_height;
    assign n_num = $signed({1'b0, r_a}) - $signed({3'b0, r_l12sq});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_reach <= {1'b0, w_root} - {2'b0, r_shoulder_offset};
            r_r2    <= n_r2[48:0];
            r_h2    <= n_h2[48:0];
            r_a     <= {1'b0, r_r2} + {1'b0, r_h2};
            r_num   <= n_num;
        end
    end

    // saturation check and rounded dividend
    logic [50:0]      n_anum;
    logic             r_neg;
    logic             r_sat;
    logic [DIV_W-1:0] r_dvd;

    assign n_anum = r_num[50] ? 51'(-r_num) : r_num;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_neg <= r_num[50];
            r_sat <= (n_anum > {4'b0, w_den});
            r_dvd <= {n_anum[DEN_W-1:0], 16'b0} + {{(DIV_W-2*LEN_W){1'b0}}, r_l1l2};
        end
    end

    logic [Q_W-1:0] w_quo;

    aik_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_dvd),
        .i_den (w_den),
        .o_quo (w_quo)
    );

    logic [1:0] w_ns;

    aik_delay #(.WIDTH(2), .DEPTH(L_DIV)) u_dly_sign (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r_neg, r_sat}),
        .o_q   (w_ns)
    );

    logic w_flag;

    aik_delay #(.WIDTH(1), .DEPTH(T_AT - T_C5)) u_dly_flag (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_sat),
        .o_q   (w_flag)
    );

    // elbow cosine and sine argument
    logic [Q_W-1:0]       n_cmag;
    logic signed [Q_W:0]  r_cq;
    logic signed [35:0]   n_cq2;
    logic [SQ2_IN_W-1:0]  r_arg;

    assign n_cmag = w_ns[0] ? Q_W'(65536) : w_quo;
    assign n_cq2  = r_cq * r_cq;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cq  <= w_ns[1] ? -$signed({1'b0, n_cmag}) : $signed({1'b0, n_cmag});
            r_arg <= SQ2_IN_W'(34'h1_0000_0000) - n_cq2[SQ2_IN_W-1:0];
        end
    end

    logic [L_SQ2-1:0] w_sin;

    aik_isqrt #(.W(SQ2_IN_W)) u_sqrt_sin (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_val  (r_arg),
        .o_root (w_sin)
    );

    logic signed [Q_W:0] w_cq;

    aik_delay #(.WIDTH(Q_W + 1), .DEPTH(T_SQ2 - T_D1)) u_dly_cq (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_cq),
        .o_q   (w_cq)
    );

    // elbow triangle terms
    logic [39:0]         n_ls;
    logic signed [41:0]  n_cl;
    logic [39:0]         r_ls;
    logic signed [41:0]  r_cl;
    logic signed [Q_W:0] r_nsin;
    logic signed [Q_W:0] r_cq1;
    logic signed [41:0]  r_tx;
    logic signed [41:0]  r_ty;
    logic signed [Q_W:0] r_ey;
    logic signed [Q_W:0] r_ex;

    assign n_ls = r_l2 * w_sin;
    assign n_cl = w_cq * $signed({1'b0, r_l2});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ls   <= n_ls;
            r_cl   <= n_cl;
            r_nsin <= -$signed({1'b0, w_sin});
            r_cq1  <= w_cq;
            r_tx   <= $signed({3'b0, r_l1, 16'b0}) + r_cl;
            r_ty   <= -$signed({2'b0, r_ls});
            r_ey   <= r_nsin;
            r_ex   <= r_cq1;
        end
    end

    // angle units
    logic [ANG_W-1:0] w_base;
    logic [ANG_W-1:0] w_base_d;
    logic [ANG_W-1:0] w_sh1;
    logic [ANG_W-1:0] w_sh1_d;
    logic [ANG_W-1:0] w_sh2;
    logic [ANG_W-1:0] w_elbow;

    aik_atan2 #(.W(COORD_W)) u_atan_base (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_y),
        .i_x   (r_x),
        .o_ang (w_base)
    );

    aik_delay #(.WIDTH(ANG_W), .DEPTH(T_AT - AT_LAT)) u_dly_base (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (w_base),
        .o_q   (w_base_d)
    );

    aik_atan2 #(.W(COORD_W + 1)) u_atan_plane (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (w_height),
        .i_x   (r_reach),
        .o_ang (w_sh1)
    );

    aik_delay #(.WIDTH(ANG_W), .DEPTH(T_AT - T_C1 - AT_LAT)) u_dly_plane (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (w_sh1),
        .o_q   (w_sh1_d)
    );

    aik_atan2 #(.W(42)) u_atan_link (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_ty),
        .i_x   (r_tx),
        .o_ang (w_sh2)
    );

    aik_atan2 #(.W(Q_W + 1)) u_atan_elbow (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_ey),
        .i_x   (r_ex),
        .o_ang (w_elbow)
    );

    // output register
    logic [ANG_W-1:0] r_base_angle;
    logic [ANG_W-1:0] r_shoulder_angle;
    logic [ANG_W-1:0] r_elbow_angle;
    logic             r_unreachable;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_base_angle     <= w_base_d;
            r_shoulder_angle <= w_sh1_d - w_sh2 - ANG_W'(16384);
            r_elbow_angle    <= w_elbow;
            r_unreachable    <= w_flag;
        end
    end

    assign o_base_angle     = r_base_angle;
    assign o_shoulder_angle = r_shoulder_angle;
    assign o_elbow_angle    = r_elbow_angle;
    assign o_unreachable    = r_unreachable;

endmodule

`default_nettype wire

[tb/sv/aik_joint_checker.sv]
// watches the arm inverse kinematics channels, predicts joint angles and compares results
`timescale 1ns / 1ps

module aik_joint_checker
    import aik_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_stall,
    input  wire logic signed [COORD_W-1:0] i_target_x,
    input  wire logic signed [COORD_W-1:0] i_target_y,
    input  wire logic signed [COORD_W-1:0] i_target_z,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_stall,
    input  wire logic signed [ANG_W-1:0]   i_base_angle,
    input  wire logic signed [ANG_W-1:0]   i_shoulder_angle,
    input  wire logic signed [ANG_W-1:0]   i_elbow_angle,
    input  wire logic                      i_unreachable,
    input  wire logic                      i_cfg_valid,
    input  wire logic                      i_cfg_ready,
    input  wire logic [1:0]                i_cfg_index,
    input  wire logic [COORD_W-1:0]        i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef struct packed {
        logic [ANG_W-1:0] base;
        logic [ANG_W-1:0] shoulder;
        logic [ANG_W-1:0] elbow;
        logic             unreachable;
    } t_joint_set;

    localparam longint ATAN_STEP [CORDIC_STEPS] = '{
        262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608, 1304, 652,
        326, 163, 81, 41, 20, 10, 5, 3, 1, 1
    };

    t_joint_set                expected_joints[$];
    logic [LEN_W-1:0]          shoulder_offset;
    logic [LEN_W-1:0]          upper_len;
    logic [LEN_W-1:0]          fore_len;
    logic signed [COORD_W-1:0] base_height;
    t_joint_set                got;
    t_joint_set                want;

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    // cordic atan2 in units of pi/32768
    function automatic logic [ANG_W-1:0] atan2_units(input longint y, input longint x);
        longint unsigned ax, ay, m;
        longint          cx, cy, nx, ny, z, a;
        int unsigned     r;
        ax = magnitude(x);
        ay = magnitude(y);
        m  = (ax > ay) ? ax : ay;
        z  = 0;
        if (m == 0) return '0;
        while (m < (64'd1 << 29)) begin
            m = m << 1; ax = ax << 1; ay = ay << 1;
        end
        while (m >= (64'd1 << 30)) begin
            m = m >> 1; ax = ax >> 1; ay = ay >> 1;
        end
        cx = ax;
        cy = ay;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (cy >= 0) begin
                nx = cx + (cy >>> i); ny = cy - (cx >>> i); z = z + ATAN_STEP[i];
            end else begin
                nx = cx - (cy >>> i); ny = cy + (cx >>> i); z = z - ATAN_STEP[i];
            end
            cx = nx;
            cy = ny;
        end
        a = (z + 16) >>> 5;
        if (a < 0) a = 0;
        if (a > 16384) a = 16384;
        r = a;
        if (x < 0) r = 32768 - r;
        if (y < 0) r = 0 - r;
        return r[ANG_W-1:0];
    endfunction

    function automatic t_joint_set solve_joints(input longint x, input longint y,
                                                input longint z);
        t_joint_set      js;
        longint          l1, l2, reach, height, num, den, cq, s;
        longint unsigned q;
        logic [ANG_W-1:0] sh;
        l1 = (upper_len == 0) ? 1 : longint'(upper_len);
        l2 = (fore_len == 0) ? 1 : longint'(fore_len);
        js.base = atan2_units(y, x);
        reach  = longint'(floor_sqrt(x * x + y * y)) - longint'(shoulder_offset);
        height = z - longint'(base_height);
        num = reach * reach + height * height - l1 * l1 - l2 * l2;
        den = 2 * l1 * l2;
        js.unreachable = 1'b0;
        if (num > den) begin
            cq = 65536; js.unreachable = 1'b1;
        end else if (num < -den) begin
            cq = -65536; js.unreachable = 1'b1;
        end else begin
            q  = ((magnitude(num) << 16) + longint'(den) / 2) / longint'(den);
            cq = (num < 0) ? -longint'(q) : longint'(q);
        end
        s = floor_sqrt((64'd1 << 32) - longint'(cq * cq));
        js.elbow = atan2_units(-s, cq);
        sh = atan2_units(height, reach) - atan2_units(-(l2 * s), l1 * 65536 + cq * l2);
        js.shoulder = sh - 16'd16384;
        return js;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shoulder_offset <= '0;
            upper_len       <= LEN_W'(4096);
            fore_len        <= LEN_W'(4096);
            base_height     <= '0;
            o_fail_count    <= 0;
            o_pending       <= 0;
            expected_joints.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_base_angle, i_shoulder_angle, i_elbow_angle, i_unreachable};
                if (expected_joints.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result beat: %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_joints.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: base %0d/%0d shoulder %0d/%0d",
                                      " elbow %0d/%0d unr %0d/%0d"},
                                     $signed(want.base), $signed(got.base),
                                     $signed(want.shoulder), $signed(got.shoulder),
                                     $signed(want.elbow), $signed(got.elbow),
                                     want.unreachable, got.unreachable);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_joints.push_back(solve_joints(i_target_x, i_target_y, i_target_z));
            o_pending <= expected_joints.size();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SHOULDER_OFFSET:   shoulder_offset <= i_cfg_data[LEN_W-1:0];
                    CFG_UPPER_LINK_LENGTH: upper_len       <= i_cfg_data[LEN_W-1:0];
                    CFG_FORE_LINK_LENGTH:  fore_len        <= i_cfg_data[LEN_W-1:0];
                    CFG_BASE_HEIGHT:       base_height     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

[tb/sv/tb_arm_inverse_kinematics_3dof.sv]
// stimulus and verdict for the arm inverse kinematics block
`timescale 1ns / 1ps

module tb_arm_inverse_kinematics_3dof;
    import aik_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic signed [COORD_W-1:0] i_target_x;
    logic signed [COORD_W-1:0] i_target_y;
    logic signed [COORD_W-1:0] i_target_z;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [ANG_W-1:0]   o_base_angle;
    logic signed [ANG_W-1:0]   o_shoulder_angle;
    logic signed [ANG_W-1:0]   o_elbow_angle;
    logic                      o_unreachable;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [1:0]                i_cfg_index;
    logic [COORD_W-1:0]        i_cfg_data;
    int                        fail_count;
    int                        pending;
    int                        hold_cycles;
    bit                        calm;
    bit                        sender_calm;
    int                        cycle_count;
    int                        reach_scale;

    arm_inverse_kinematics_3dof uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_target_x(i_target_x), .i_target_y(i_target_y), .i_target_z(i_target_z),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_base_angle(o_base_angle), .o_shoulder_angle(o_shoulder_angle),
        .o_elbow_angle(o_elbow_angle), .o_unreachable(o_unreachable),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    aik_joint_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_target_x(i_target_x), .i_target_y(i_target_y), .i_target_z(i_target_z),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_base_angle(o_base_angle), .i_shoulder_angle(o_shoulder_angle),
        .i_elbow_angle(o_elbow_angle), .i_unreachable(o_unreachable),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count = cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // output side stall
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < 34);
            end
        end
    end

    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z);
        if (!sender_calm && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_target_x <= x;
        i_target_y <= y;
        i_target_z <= z;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (110) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [COORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_arm(input logic [COORD_W-1:0] off, input logic [COORD_W-1:0] l1,
                           input logic [COORD_W-1:0] l2, input logic [COORD_W-1:0] bh);
        write_reg(CFG_SHOULDER_OFFSET, off);
        write_reg(CFG_UPPER_LINK_LENGTH, l1);
        write_reg(CFG_FORE_LINK_LENGTH, l2);
        write_reg(CFG_BASE_HEIGHT, bh);
        reach_scale = int'(off[LEN_W-1:0]) + int'(l1[LEN_W-1:0]) + int'(l2[LEN_W-1:0])
                      + 4096;
        if (reach_scale > 4000000) reach_scale = 4000000;
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(input int scale);
        if ($urandom_range(99) < 75)
            return COORD_W'(int'($urandom_range(0, 2 * scale)) - scale);
        return COORD_W'($urandom);
    endfunction

    task automatic random_points(input int count, input bit with_holdoff);
        for (int n = 0; n < count; n++) begin
            if (with_holdoff && n == 40) hold_cycles = 400;
            send_point(pick_coord(reach_scale), pick_coord(reach_scale),
                       pick_coord(reach_scale));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_target_x  = '0;
        i_target_y  = '0;
        i_target_z  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        hold_cycles = 0;
        calm        = 1'b0;
        sender_calm = 1'b0;
        reach_scale = 12288;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed points at reset geometry
        send_point(24'sd0, 24'sd0, 24'sd0);
        send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_point(24'sh800000, 24'sh800000, 24'sh800000);
        send_point(24'sh7FFFFF, 24'sh800000, 24'sd0);
        send_point(-24'sd4096, 24'sd0, 24'sd0);
        send_point(24'sd8192, 24'sd0, 24'sd0);
        send_point(24'sd0, 24'sd8192, 24'sd0);
        send_point(24'sd0, 24'sd0, 24'sd8192);
        send_point(24'sd4096, 24'sd4096, 24'sd0);
        send_point(-24'sd4096, -24'sd2048, 24'sd3000);
        send_point(24'sd2048, -24'sd3000, -24'sd1000);
        send_point(24'sd100, 24'sd0, 24'sd0);
        send_point(24'sd40000, 24'sd0, 24'sd0);
        drain();
        set_arm(24'd0, 24'd8192, 24'd4096, 24'd0);
        send_point(24'sd0, 24'sd0, 24'sd0);
        send_point(24'sd4096, 24'sd0, 24'sd0);
        send_point(24'sd12288, 24'sd0, 24'sd0);
        send_point(24'sd0, 24'sd0, 24'sd20000);
        drain();
        set_arm(24'd0, 24'd0, 24'd0, 24'd0);
        send_point(24'sd1, 24'sd0, 24'sd0);
        send_point(24'sd2, 24'sd0, 24'sd0);
        send_point(24'sd0, 24'sd0, 24'sd0);
        drain();

        set_arm(24'd0, 24'd4096, 24'd4096, 24'd0);
        random_points(180, 1'b1);
        drain();
        set_arm(24'd2048, 24'd12000, 24'd7000, 24'sd3000);
        calm = 1'b1;
        sender_calm = 1'b1;
        random_points(150, 1'b0);
        calm = 1'b0;
        sender_calm = 1'b0;
        drain();
        set_arm(24'h7FFFFF, 24'h7FFFFF, 24'd1, 24'h800000);
        random_points(150, 1'b0);
        drain();
        set_arm(24'd1, 24'd1, 24'h7FFFFF, 24'h7FFFFF);
        random_points(150, 1'b0);
        drain();
        set_arm({1'b0, 23'($urandom_range(0, 100000))}, 24'($urandom_range(1, 200000)),
                24'($urandom_range(1, 200000)), 24'($urandom_range(0, 200000)) - 24'd100000);
        random_points(150, 1'b0);
        drain();
        set_arm(24'd0, 24'd4096, 24'd4096, 24'd0);
        random_points(150, 1'b1);
        drain();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
